[design/pcs_pkg.sv]
// Shared constants, types and the arctangent table of the polar-to-Cartesian converter.
package pcs_pkg;

   // Configuration
   localparam int RANGE_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int INDEX_WIDTH   = 12;

   // Fixed-point layout
   localparam int STAGE_LIMIT = 24;
   localparam int STAGES_USED = (CORDIC_STAGES < STAGE_LIMIT) ? CORDIC_STAGES : STAGE_LIMIT;
   localparam int STG_W       = $clog2(STAGE_LIMIT);
   localparam int FRAC_BITS   = 16;
   localparam int GAIN_W      = 30;
   localparam int XY_W        = RANGE_WIDTH + FRAC_BITS + 3;
   localparam int Z_W         = 33;
   localparam int RES_W       = RANGE_WIDTH + 1;
   localparam int ANGLE_W     = 32;
   localparam int ZMM_W       = 16;

   // Gain compensation 0.60725293500888 in Q30
   localparam logic [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(652032874);

   // Register indexes of the write port
   typedef enum logic [1:0] {
      CSR_ANGLE_START = 2'd0,
      CSR_ANGLE_STEP  = 2'd1,
      CSR_Z_COORD     = 2'd2
   } pcs_csr_type;

   // Vector carried along the rotation chain
   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
      logic [INDEX_WIDTH-1:0]  idx;
   } pcs_vec_type;

   // round(atan(2^-i) * 2^32 / (2*pi))
   function automatic logic [ANGLE_W-1:0] pcs_atan(input logic [STG_W-1:0] i);
      logic [ANGLE_W-1:0] v;
      case (i)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[design/polar_scan_to_cartesian.sv]
// Polar scan to Cartesian converter: one range sample in, at most one x/y/z point out,
// using a chain of CORDIC rotation cells. One sample is taken every clock cycle unless the
// chain is stalled; a point passes through the front register, one cell per CORDIC stage
// and the result register. Each cell stalls on its own, so gaps in the chain close up
// while the output is held. Samples with range_valid low only advance the angle and
// give no point.
module polar_scan_to_cartesian import pcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   // Sample channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,   // [15:0] range_mm
   input  logic [1:0]    req_tuser,   // [0] range_valid, [1] scan_start
   // Point channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // [16:0] x_mm, [33:17] y_mm, [49:34] z_mm,
                                      // [61:50] point_index, [63:62] zero
   // Register write port
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic [31:0]   csr_wdata
);

   logic [ANGLE_W-1:0]     angle_start_ff, angle_step_ff;
   logic [ZMM_W-1:0]       z_cfg_ff;
   logic                   chain_valid [0:STAGES_USED];
   logic                   chain_ready [0:STAGES_USED];
   pcs_vec_type            chain_data  [0:STAGES_USED];
   logic [STAGES_USED:0]   busy;
   logic [RES_W-1:0]       x_mm, y_mm;
   logic [ZMM_W-1:0]       z_mm;
   logic [INDEX_WIDTH-1:0] point_index;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_start_ff <= '0;
         angle_step_ff  <= '0;
         z_cfg_ff       <= ZMM_W'(200);
      end else if (csr_we) begin
         case (pcs_csr_type'(csr_addr))
            CSR_ANGLE_START: angle_start_ff <= csr_wdata;
            CSR_ANGLE_STEP:  angle_step_ff  <= csr_wdata;
            CSR_Z_COORD:     z_cfg_ff       <= csr_wdata[ZMM_W-1:0];
            default:         ;
         endcase
      end
   end

   pcs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .range_mm    (req_tdata[RANGE_WIDTH-1:0]),
      .range_valid (req_tuser[0]),
      .scan_start  (req_tuser[1]),
      .angle_start (angle_start_ff),
      .angle_step  (angle_step_ff),
      .out_valid   (chain_valid[0]),
      .out_data    (chain_data[0]),
      .out_ready   (chain_ready[0])
   );

   // Rotation cells, one per CORDIC stage
   for (genvar k = 0; k < STAGES_USED; k++) begin : g_cell
      pcs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (STG_W'(k)),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_data  (chain_data[k+1]),
         .out_ready (chain_ready[k+1])
      );
   end

   for (genvar k = 0; k <= STAGES_USED; k++) begin : g_busy
      assign busy[k] = chain_valid[k];
   end

   pcs_out u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (chain_valid[STAGES_USED]),
      .in_ready    (chain_ready[STAGES_USED]),
      .in_data     (chain_data[STAGES_USED]),
      .z_cfg       (z_cfg_ff),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .x_mm        (x_mm),
      .y_mm        (y_mm),
      .z_mm        (z_mm),
      .point_index (point_index)
   );

   assign rsp_tdata = {2'b00, point_index, z_mm, y_mm, x_mm};

`ifndef NO_ASSERTIONS
   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("point valid right after reset");

   // An empty result register never stalls the chain or the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // An empty chain cannot produce a point in the next cycle
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && busy == '0) |=> !rsp_tvalid)
      else $error("point appeared from an empty chain");
`endif

endmodule

[design/pcs_front.sv]
// Scan angle and point index tracking, angle folding and gain-scaled start vector.
module pcs_front import pcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [RANGE_WIDTH-1:0]   range_mm,
   input  logic                     range_valid,
   input  logic                     scan_start,
   input  logic [ANGLE_W-1:0]       angle_start,
   input  logic [ANGLE_W-1:0]       angle_step,
   output logic                     out_valid,
   output pcs_vec_type              out_data,
   input  logic                     out_ready
);

   localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;
   localparam int PROD_W = RANGE_WIDTH + GAIN_W;

   logic [ANGLE_W-1:0]     angle_ff, angle_in, angle_eff, angle_fold;
   logic [INDEX_WIDTH-1:0] count_ff, count_in, count_eff;
   logic                   valid_ff;
   pcs_vec_type            data_ff, data_in;
   logic                   accept, fold;
   logic [PROD_W-1:0]      prod;
   logic signed [XY_W-1:0] x0;

   assign req_ready = !valid_ff || out_ready;
   assign accept    = req_valid && req_ready;

   // Scan start reloads angle and index before the sample is used
   always_comb begin
      angle_eff = scan_start ? angle_start : angle_ff;
      count_eff = scan_start ? '0 : count_ff;
      angle_in  = angle_ff;
      count_in  = count_ff;
      if (accept) begin
         angle_in = angle_eff + angle_step;
         count_in = count_eff;
         if (range_valid && count_eff != IDX_MAX) begin
            count_in = count_eff + INDEX_WIDTH'(1);
         end
      end
   end

   // Fold into [-1/4, 1/4] turn; start vector is range * gain in Q16
   always_comb begin
      fold       = angle_eff[ANGLE_W-1] ^ angle_eff[ANGLE_W-2];
      angle_fold = {angle_eff[ANGLE_W-1] ^ fold, angle_eff[ANGLE_W-2:0]};
      prod       = PROD_W'(range_mm) * PROD_W'(GAIN_Q30);
      x0         = XY_W'(prod[PROD_W-1:GAIN_W-FRAC_BITS]);
      data_in.x   = fold ? -x0 : x0;
      data_in.y   = '0;
      data_in.z   = Z_W'($signed(angle_fold));
      data_in.idx = count_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         angle_ff <= angle_in;
         count_ff <= count_in;
         if (req_ready) begin
            valid_ff <= accept && range_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[design/pcs_cell.sv]
// One rotation step of the CORDIC chain with its own valid bit and stall.
module pcs_cell import pcs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [STG_W-1:0]  stage_idx,
   input  logic              in_valid,
   output logic              in_ready,
   input  pcs_vec_type       in_data,
   output logic              out_valid,
   output pcs_vec_type       out_data,
   input  logic              out_ready
);

   logic                   valid_ff;
   pcs_vec_type            data_ff, data_in;
   logic signed [XY_W-1:0] dx, dy;
   logic signed [Z_W-1:0]  da;

   // Cell can take a beat when empty or when its content moves on
   assign in_ready = !valid_ff || out_ready;

   // Rotate toward zero residual angle
   always_comb begin
      dx = in_data.y >>> stage_idx;
      dy = in_data.x >>> stage_idx;
      da = Z_W'(pcs_atan(stage_idx));
      data_in.idx = in_data.idx;
      if (!in_data.z[Z_W-1]) begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.z = in_data.z - da;
      end else begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.z = in_data.z + da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[design/pcs_out.sv]
// Rounding, saturation and the result register toward the output channel.
module pcs_out import pcs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  pcs_vec_type             in_data,
   input  logic [ZMM_W-1:0]        z_cfg,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RES_W-1:0]        x_mm,
   output logic [RES_W-1:0]        y_mm,
   output logic [ZMM_W-1:0]        z_mm,
   output logic [INDEX_WIDTH-1:0]  point_index
);

   localparam int SUM_W = XY_W + 1;
   localparam int RND_W = SUM_W - FRAC_BITS;
   localparam logic signed [RND_W-1:0] HI = RND_W'((64'sd1 <<< RANGE_WIDTH) - 64'sd1);
   localparam logic signed [RND_W-1:0] LO = -RND_W'(64'sd1 <<< RANGE_WIDTH);

   logic                   valid_ff;
   logic [RES_W-1:0]       x_ff, y_ff;
   logic [ZMM_W-1:0]       z_ff;
   logic [INDEX_WIDTH-1:0] idx_ff;
   logic [RES_W-1:0]       x_in, y_in;

   // Round half up from Q16, then clamp to the result range
   function automatic logic [RES_W-1:0] to_mm(input logic signed [XY_W-1:0] v);
      logic signed [SUM_W-1:0] s;
      logic signed [RND_W-1:0] r;
      s = SUM_W'(v) + SUM_W'(1 <<< (FRAC_BITS - 1));
      r = RND_W'(s >>> FRAC_BITS);
      if (r > HI) begin
         r = HI;
      end else if (r < LO) begin
         r = LO;
      end
      return r[RES_W-1:0];
   endfunction

   assign in_ready = !valid_ff || rsp_ready;
   assign x_in     = to_mm(in_data.x);
   assign y_in     = to_mm(in_data.y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_cfg;
         idx_ff <= in_data.idx;
      end
   end

   assign rsp_valid   = valid_ff;
   assign x_mm        = x_ff;
   assign y_mm        = y_ff;
   assign z_mm        = z_ff;
   assign point_index = idx_ff;

endmodule

[tb/polar_scan_to_cartesian_test.sv]
// Self-checking testbench for the polar scan to Cartesian point converter.
`timescale 1ns / 1ps

module polar_scan_to_cartesian_test;
   import pcs_pkg::*;

   // Timing and limits
   localparam int PIPE_DEPTH     = STAGES_USED + 2;
   localparam int SETTLE_CYCLES  = PIPE_DEPTH + 4;
   localparam int WATCHDOG_LIMIT = 2000;

   // Fixed-point constants of the predictor
   localparam longint GAIN_COMP = 64'sd652032874;          // 0.607252935 in Q30
   localparam longint XY_MAX    = (64'sd1 <<< RANGE_WIDTH) - 1;
   localparam longint XY_MIN    = -(64'sd1 <<< RANGE_WIDTH);

   // One point as it leaves the block
   typedef struct packed {
      logic [RES_W-1:0]       x;
      logic [RES_W-1:0]       y;
      logic [ZMM_W-1:0]       z;
      logic [INDEX_WIDTH-1:0] idx;
   } point_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [15:0]   req_tdata = '0;    // [15:0] range_mm
   logic [1:0]    req_tuser = '0;    // [0] range_valid, [1] scan_start
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [63:0]   rsp_tdata;         // [16:0] x_mm, [33:17] y_mm, [49:34] z_mm,
                                     // [61:50] point_index, [63:62] zero
   logic          csr_we = 1'b0;
   logic [1:0]    csr_addr = '0;
   logic [31:0]   csr_wdata = '0;

   // Predictor state and register copies
   logic [ANGLE_W-1:0]     cfg_start = '0;
   logic [ANGLE_W-1:0]     cfg_step = '0;
   logic [ZMM_W-1:0]       cfg_z = 16'd200;
   logic [ANGLE_W-1:0]     cur_angle = '0;
   logic [INDEX_WIDTH-1:0] valid_count = '0;

   point_type pending_points[$];
   int        error_count = 0;
   int        quiet_cycles = 0;
   int        ready_hold = 0;
   bit        send_gaps_on = 1'b1;
   bit        rsp_stalls_on = 1'b1;

   // Arctangent of 2^-i in binary angle units
   longint atan_tbl [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   polar_scan_to_cartesian uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Round half up out of Q16 and clamp to the output range
   function automatic logic [RES_W-1:0] round_mm(input longint v);
      longint r;
      r = (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > XY_MAX) r = XY_MAX;
      if (r < XY_MIN) r = XY_MIN;
      return r[RES_W-1:0];
   endfunction

   // Rotation-mode CORDIC of (range, 0) by the binary angle
   function automatic point_type rotate_sample(input logic [15:0] rng,
                                               input logic [ANGLE_W-1:0] ang);
      point_type p;
      longint x, y, z, dx, dy;
      logic [ANGLE_W-1:0] a;
      a = ang;
      x = (longint'({48'd0, rng[RANGE_WIDTH-1:0]}) * GAIN_COMP) >>> (30 - FRAC_BITS);
      y = 0;
      // fold the left half plane onto the right one
      if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
         x = -x;
         a = a - 32'h8000_0000;
      end
      z = longint'($signed(a));
      for (int i = 0; i < STAGES_USED; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_tbl[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_tbl[i];
         end
      end
      p = '0;
      p.x = round_mm(x);
      p.y = round_mm(y);
      return p;
   endfunction

   // Advance the predictor by one accepted sample
   function automatic void accept_sample(input logic [15:0] rng, input logic ok,
                                         input logic first);
      point_type p;
      if (first) begin
         cur_angle   = cfg_start;
         valid_count = '0;
      end
      if (ok) begin
         p     = rotate_sample(rng, cur_angle);
         p.z   = cfg_z;
         p.idx = valid_count;
         pending_points.insert(pending_points.size(), p);
         if (valid_count != '1) valid_count = valid_count + 1'b1;
      end
      cur_angle = cur_angle + cfg_step;
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Send one sample beat and record its prediction when accepted
   task automatic send_sample(input logic [15:0] rng, input logic ok, input logic first);
      int gap;
      gap = send_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rng;
      req_tuser  <= {first, ok};
      do @(posedge clock); while (!req_tready);
      accept_sample(rng, ok, first);
   endtask

   // Hold off until every point has come out, then let the chain empty
   task automatic wait_drained(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Register write; only called while the block is idle
   task automatic write_reg(input pcs_csr_type which, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= which;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (which)
         CSR_ANGLE_START: cfg_start = value;
         CSR_ANGLE_STEP:  cfg_step  = value;
         CSR_Z_COORD:     cfg_z     = value[ZMM_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_scan(input logic [31:0] start, input logic [31:0] step,
                           input logic [15:0] z);
      wait_drained(SETTLE_CYCLES);
      write_reg(CSR_ANGLE_START, start);
      write_reg(CSR_ANGLE_STEP, step);
      write_reg(CSR_Z_COORD, {16'd0, z});
   endtask

   // Point channel backpressure: bursts of ready, short stalls, a few long ones
   always @(posedge clock) begin
      int r;
      if (ready_hold > 0) begin
         ready_hold--;
      end else if (!rsp_stalls_on) begin
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_tready <= 1'b1;
            ready_hold = $urandom_range(0, 7);
         end else if (r < 93) begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(3, 40);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
   endtask

   // Compare each point beat with the oldest prediction
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            report_mismatch("unexpected point", rsp_tdata, 64'd0);
         end else begin
            want = pending_points.pop_front();
            if (rsp_tdata[16:0] !== want.x)
               report_mismatch("x_mm", rsp_tdata[16:0], want.x);
            if (rsp_tdata[33:17] !== want.y)
               report_mismatch("y_mm", rsp_tdata[33:17], want.y);
            if (rsp_tdata[49:34] !== want.z)
               report_mismatch("z_mm", rsp_tdata[49:34], want.z);
            if (rsp_tdata[61:50] !== want.idx)
               report_mismatch("point_index", rsp_tdata[61:50], want.idx);
            if (rsp_tdata[63:62] !== 2'b00)
               report_mismatch("pad bits", rsp_tdata[63:62], 64'd0);
         end
      end
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d points outstanding",
                     quiet_cycles, pending_points.size());
            $display("polar_scan_to_cartesian_test: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset values: angle 0, no step, z of 200; range extremes and a dropped sample
   task automatic test_reset_defaults();
      send_sample(16'd0, 1'b1, 1'b1);
      send_sample(16'hFFFF, 1'b1, 1'b0);
      send_sample(16'd1, 1'b1, 1'b0);
      send_sample(16'hFFFF, 1'b0, 1'b0);
      send_sample(16'h8000, 1'b1, 1'b0);
   endtask

   // Quadrant edges, angle wrap, extreme steps and z, reload on a dropped sample
   task automatic test_quadrant_edges();
      set_scan(32'hFFFF_FFFF, 32'h4000_0000, 16'h8000);
      send_sample(16'hFFFF, 1'b1, 1'b1);
      send_sample(16'hFFFF, 1'b1, 1'b0);
      send_sample(16'd40000, 1'b1, 1'b0);
      send_sample(16'hFFFF, 1'b1, 1'b0);
      send_sample(16'd12345, 1'b0, 1'b0);
      send_sample(16'hFFFF, 1'b1, 1'b0);
      send_sample(16'd0, 1'b0, 1'b1);        // scan start on a dropped sample
      send_sample(16'hFFFF, 1'b1, 1'b0);

      set_scan(32'h4000_0000, 32'h8000_0000, 16'h7FFF);
      send_sample(16'hFFFF, 1'b1, 1'b1);
      send_sample(16'hFFFF, 1'b1, 1'b0);
      send_sample(16'h8000, 1'b1, 1'b0);
      send_sample(16'h7FFF, 1'b1, 1'b0);

      set_scan(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
      send_sample(16'hFFFF, 1'b1, 1'b1);
      send_sample(16'hFFFF, 1'b1, 1'b0);
      send_sample(16'hFFFF, 1'b1, 1'b0);
      send_sample(16'd1, 1'b1, 1'b0);
   endtask

   // Back-to-back burst with the output always ready, then an index restart
   task automatic test_back_to_back();
      int n;
      set_scan($urandom, 32'h00B6_0B61, 16'($urandom_range(0, 65535)));
      send_gaps_on  = 1'b0;
      rsp_stalls_on = 1'b0;
      send_sample(16'($urandom_range(0, 65535)), 1'b1, 1'b1);
      for (n = 0; n < 40; n++)
         send_sample(16'($urandom_range(0, 65535)), ($urandom_range(0, 19) != 0), 1'b0);
      send_sample(16'($urandom_range(0, 65535)), 1'b1, 1'b1);   // index restarts at zero
      send_sample(16'($urandom_range(0, 65535)), 1'b1, 1'b0);
      send_gaps_on  = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Sender waits for every point before continuing the scan
   task automatic test_pause_until_drained();
      int n;
      set_scan($urandom, $urandom, 16'($urandom_range(0, 65535)));
      for (n = 0; n < 12; n++)
         send_sample(16'($urandom_range(0, 65535)), 1'b1, (n == 0));
      wait_drained(0);
      for (n = 0; n < 12; n++)
         send_sample(16'($urandom_range(0, 65535)), ($urandom_range(0, 3) != 0), 1'b0);
   endtask

   // Random scans over several register settings
   task automatic test_random_scans();
      int phase, n, scan_left, r;
      logic [31:0] start, step;
      logic [15:0] z, rng;
      logic ok, first;
      for (phase = 0; phase < 7; phase++) begin
         start = $urandom;
         z     = 16'($urandom_range(0, 65535));
         case (phase)
            0: begin step = 32'h0000_0001; start = 32'h0000_0000; z = 16'h8000; end
            1: begin step = 32'h7FFF_FFFF; start = 32'hFFFF_FFFF; z = 16'h7FFF; end
            2: step = 32'h8000_0000;
            3: step = 32'hFFFF_FFFF;
            4: step = 32'h00B6_0B61;
            5: step = -32'sh00B6_0B61;
            default: step = $urandom;
         endcase
         set_scan(start, step, z);
         scan_left = 0;
         for (n = 0; n < 52; n++) begin
            first = 1'b0;
            if (scan_left == 0) begin
               scan_left = $urandom_range(3, 40);
               first = 1'b1;
            end
            scan_left--;
            if ($urandom_range(0, 99) < 4) first = 1'b1;   // stray scan start
            ok = ($urandom_range(0, 99) < 85);
            r  = $urandom_range(0, 9);
            if (r == 0) rng = 16'd0;
            else if (r == 1) rng = 16'hFFFF;
            else rng = 16'($urandom_range(0, 65535));
            send_sample(rng, ok, first);
            if ($urandom_range(0, 59) == 0) wait_drained(0);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_quadrant_edges();
      test_pause_until_drained();
      test_back_to_back();
      test_random_scans();
      wait_drained(SETTLE_CYCLES);
      if (error_count == 0) begin
         $display("polar_scan_to_cartesian_test: clean");
      end else begin
         $display("polar_scan_to_cartesian_test: errors");
      end
      $finish;
   end

endmodule
